[hdl/climate_sensor_compensation_unit_macros.svh]
// assertion macros for the climate sensor compensation block
// used by the port checker; no dependencies
`ifndef CLIMATE_SENSOR_COMPENSATION_UNIT_MACROS_SVH
`define CLIMATE_SENSOR_COMPENSATION_UNIT_MACROS_SVH

// same-cycle implication, checked at each rising edge outside reset
`define CSC_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked at each rising edge outside reset
`define CSC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/csc_pkg.sv]
// shared types and constants for the climate sensor compensation block
// no dependencies
`timescale 1ns / 1ps

package csc_pkg;

   // multiplier digit size and digit count
   localparam int DIGIT_W  = 4;
   localparam int WORD_W   = 32;
   localparam int DIGITS   = WORD_W / DIGIT_W;
   localparam int DCNT_W   = $clog2(DIGITS);

   // formula constants
   localparam logic [31:0] HUM_T_OFFSET = 32'd76800;
   localparam logic [31:0] HUM_ROUND_A  = 32'd16384;
   localparam logic [31:0] HUM_BIAS_B   = 32'd32768;
   localparam logic [31:0] HUM_BIAS_C   = 32'd2097152;
   localparam logic [31:0] HUM_ROUND_D  = 32'd8192;
   localparam logic [31:0] HUM_Q_MAX    = 32'd419430400;
   localparam logic [31:0] TEMP_ROUND   = 32'd128;

   // configuration register indexes
   localparam int CSR_IDX_W = 4;
   localparam logic [CSR_IDX_W-1:0] CSR_TEMP_ONE   = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TEMP_TWO   = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TEMP_THREE = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_HUM_ONE    = 4'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_HUM_TWO    = 4'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_HUM_THREE  = 4'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_HUM_FOUR5  = 4'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_HUM_SIX    = 4'd7;
   localparam int CSR_DATA_W = 24;

   // reading selector
   localparam logic ACT_TEMP = 1'b0;
   localparam logic ACT_HUM  = 1'b1;

   typedef struct packed {
      logic        action;
      logic [19:0] raw_count;
   } req_word_type;

   typedef struct packed {
      logic               kind;
      logic signed [31:0] reading;
   } rsp_word_type;

   typedef struct packed {
      logic [15:0]        t1;
      logic signed [15:0] t2;
      logic signed [15:0] t3;
      logic [7:0]         h1;
      logic signed [15:0] h2;
      logic [7:0]         h3;
      logic [23:0]        h45;
      logic [7:0]         h6;
   } coeff_type;

endpackage

[hdl/csc_regs.sv]
// calibration coefficient registers written through the csr channel
// depends on csc_pkg
`timescale 1ns / 1ps

module csc_regs
   import csc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output coeff_type             coeff
);

   coeff_type coeff_ff, coeff_in;

   // decode the index, indexes past the list are dropped
   always_comb begin
      coeff_in = coeff_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_TEMP_ONE:   coeff_in.t1  = csr_data[15:0];
            CSR_TEMP_TWO:   coeff_in.t2  = csr_data[15:0];
            CSR_TEMP_THREE: coeff_in.t3  = csr_data[15:0];
            CSR_HUM_ONE:    coeff_in.h1  = csr_data[7:0];
            CSR_HUM_TWO:    coeff_in.h2  = csr_data[15:0];
            CSR_HUM_THREE:  coeff_in.h3  = csr_data[7:0];
            CSR_HUM_FOUR5:  coeff_in.h45 = csr_data;
            CSR_HUM_SIX:    coeff_in.h6  = csr_data[7:0];
            default:        coeff_in     = coeff_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coeff_ff <= '0;
      end else begin
         coeff_ff <= coeff_in;
      end
   end

   assign coeff = coeff_ff;

endmodule

[hdl/csc_mul.sv]
// digit-serial 32x32 multiplier keeping the low 32 product bits
// one 4-bit digit of the multiplier per cycle; depends on csc_pkg
`timescale 1ns / 1ps

module csc_mul
   import csc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [WORD_W-1:0] op_a,
   input  logic [WORD_W-1:0] op_b,
   output logic              done,
   output logic [WORD_W-1:0] product
);

   logic [WORD_W-1:0] acc_ff, a_ff, b_ff;
   logic [DCNT_W-1:0] cnt_ff;
   logic              busy_ff, done_ff;
   logic [WORD_W-1:0] part, acc_in;

   // partial product of the multiplicand and the lowest digit
   always_comb begin
      part   = a_ff * {{(WORD_W-DIGIT_W){1'b0}}, b_ff[DIGIT_W-1:0]};
      acc_in = acc_ff + part;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + 1'b1;
         if (cnt_ff == DCNT_W'(DIGITS-1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end else begin
         done_ff <= 1'b0;
      end
   end

   // datapath shift registers
   always_ff @(posedge clock) begin
      if (start) begin
         acc_ff <= '0;
         a_ff   <= op_a;
         b_ff   <= op_b;
      end else if (busy_ff) begin
         acc_ff <= acc_in;
         a_ff   <= a_ff << DIGIT_W;
         b_ff   <= b_ff >> DIGIT_W;
      end
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

[hdl/climate_sensor_compensation_unit.sv]
// climate sensor compensation block: top level with step sequencer
// depends on csc_pkg, csc_regs and csc_mul
`timescale 1ns / 1ps
//
// Usage:
//   req channel: one word per reading, action selects temperature (0) or
//   humidity (1), raw_count holds the converter count (humidity uses 15:0).
//   rsp channel: one word per request, kind echoes action, reading is
//   hundredths of a degree C or hundredths of percent RH.
//   csr channel: always ready; index 0..7 selects a calibration register,
//   other indexes are dropped. Write only while no request is in flight.
// Sequencing: one request at a time. Each step of the formula runs one product
//   through the shared 4-bit digit-serial multiplier: load the operands, wait
//   for done, then post-process. Temperature has 4 steps, humidity 8; a new
//   request is taken the cycle after the result word is taken.
// Reset: clears coefficients and the stored fine temperature to zero and
//   returns the sequencer to idle.
// Stall: while rsp_ready is low the result word is held and req_ready stays low.
//
module climate_sensor_compensation_unit
   import csc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_word_type          req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_word_type          rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_LOAD = 4'b0010,
      ST_WAIT = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   state_type    state_ff, state_in;
   logic [2:0]   step_ff, step_in;
   logic         act_ff;
   logic [19:0]  raw_ff;
   logic [31:0]  fine_ff, fine_in;
   logic [31:0]  ra_ff, ra_in, r1_ff, r1_in, r2_ff, r2_in;
   rsp_word_type out_ff, out_in;

   coeff_type    coeff;
   logic         mul_start, mul_done;
   logic [31:0]  op_a, op_b, prod;

   // sign- or zero-extended coefficients and formula terms
   logic [31:0]  t1, t2, t3, h1, h2, h3, h4, h5, h6;
   logic [31:0]  adc_t, adc_h, x, d, hx, hc;
   logic [16:0]  hq;
   logic [21:0]  h25;
   logic [2:0]   last_step;

   csc_regs u_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .coeff     (coeff)
   );

   csc_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .op_a    (op_a),
      .op_b    (op_b),
      .done    (mul_done),
      .product (prod)
   );

   always_comb begin
      t1    = {16'b0, coeff.t1};
      t2    = {{16{coeff.t2[15]}}, coeff.t2};
      t3    = {{16{coeff.t3[15]}}, coeff.t3};
      h1    = {24'b0, coeff.h1};
      h2    = {{16{coeff.h2[15]}}, coeff.h2};
      h3    = {24'b0, coeff.h3};
      h4    = {{20{coeff.h45[23]}}, coeff.h45[23:12]};
      h5    = {{20{coeff.h45[11]}}, coeff.h45[11:0]};
      h6    = {24'b0, coeff.h6};
      adc_t = {12'b0, raw_ff};
      adc_h = {16'b0, raw_ff[15:0]};
      x     = fine_ff - HUM_T_OFFSET;
      d     = (adc_t >> 4) - t1;
      last_step = (act_ff == ACT_HUM) ? 3'd7 : 3'd3;
   end

   // multiplier operands for each step
   always_comb begin
      op_a = '0;
      op_b = '0;
      if (act_ff == ACT_TEMP) begin
         case (step_ff)
            3'd0:    begin op_a = (adc_t >> 3) - (t1 << 1); op_b = t2; end
            3'd1:    begin op_a = d;     op_b = d;     end
            3'd2:    begin op_a = r1_ff; op_b = t3;    end
            default: begin op_a = fine_ff; op_b = 32'd5; end
         endcase
      end else begin
         case (step_ff)
            3'd0:    begin op_a = h5;    op_b = x;     end
            3'd1:    begin op_a = x;     op_b = h6;    end
            3'd2:    begin op_a = x;     op_b = h3;    end
            3'd3:    begin op_a = r1_ff; op_b = r2_ff; end
            3'd4:    begin op_a = r1_ff; op_b = h2;    end
            3'd5:    begin op_a = ra_ff; op_b = r1_ff; end
            3'd6:    begin op_a = r1_ff; op_b = r1_ff; end
            default: begin op_a = r1_ff; op_b = h1;    end
         endcase
      end
   end

   // final humidity correction, clamp and scaling
   always_comb begin
      hx = r2_ff - 32'($signed(32'($signed(prod) >>> 4)));
      if (hx[31]) begin
         hc = '0;
      end else if (hx > HUM_Q_MAX) begin
         hc = HUM_Q_MAX;
      end else begin
         hc = hx;
      end
      hq  = hc[28:12];
      h25 = 22'(hq) * 22'd25;
   end

   // sequencer and post-processing of each product
   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      fine_in   = fine_ff;
      ra_in     = ra_ff;
      r1_in     = r1_ff;
      r2_in     = r2_ff;
      out_in    = out_ff;
      mul_start = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_LOAD;
               step_in  = '0;
            end
         end
         ST_LOAD: begin
            mul_start = 1'b1;
            state_in  = ST_WAIT;
         end
         ST_WAIT: begin
            if (mul_done) begin
               if (act_ff == ACT_TEMP) begin
                  case (step_ff)
                     3'd0: ra_in = 32'($signed(prod) >>> 11);
                     3'd1: r1_in = 32'($signed(prod) >>> 12);
                     3'd2: fine_in = ra_ff + 32'($signed(prod) >>> 14);
                     default: begin
                        out_in.kind    = ACT_TEMP;
                        out_in.reading = 32'($signed(prod + TEMP_ROUND) >>> 8);
                     end
                  endcase
               end else begin
                  case (step_ff)
                     3'd0: ra_in = 32'($signed((adc_h << 14) - (h4 << 20) - prod
                                              + HUM_ROUND_A) >>> 15);
                     3'd1: r1_in = 32'($signed(prod) >>> 10);
                     3'd2: r2_in = 32'($signed(prod) >>> 11) + HUM_BIAS_B;
                     3'd3: r1_in = 32'($signed(prod) >>> 10) + HUM_BIAS_C;
                     3'd4: r1_in = 32'($signed(prod + HUM_ROUND_D) >>> 14);
                     3'd5: begin
                        r2_in = prod;
                        r1_in = 32'($signed(prod) >>> 15);
                     end
                     3'd6: r1_in = 32'($signed(prod) >>> 7);
                     default: begin
                        out_in.kind    = ACT_HUM;
                        out_in.reading = {14'b0, h25[21:8], 4'b0} >> 4;
                     end
                  endcase
               end
               if (step_ff == last_step) begin
                  state_in = ST_DONE;
               end else begin
                  step_in  = step_ff + 1'b1;
                  state_in = ST_LOAD;
               end
            end
         end
         ST_DONE: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
         fine_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         fine_ff  <= fine_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_valid) begin
         act_ff <= req_data.action;
         raw_ff <= req_data.raw_count;
      end
      ra_ff  <= ra_in;
      r1_ff  <= r1_in;
      r2_ff  <= r2_in;
      out_ff <= out_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_DONE);
   assign rsp_data  = out_ff;
   assign csr_ready = 1'b1;

endmodule

[hdl/csc_checker.sv]
// port-level checker for the climate sensor compensation block and its bind
// depends on csc_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "climate_sensor_compensation_unit_macros.svh"

module csc_checker
   import csc_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input rsp_word_type          rsp_data
);

   // a stalled result word holds
   `CSC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_data), "result word changed while stalled")

   // no result in the cycle right after a request is taken
   `CSC_ASSERT_NEXT(a_no_early_rsp, clock, reset, req_valid && req_ready,
      !rsp_valid, "result shown too early")

   // a taken result word is not repeated
   `CSC_ASSERT_NEXT(a_one_rsp, clock, reset, rsp_valid && rsp_ready,
      !rsp_valid, "result repeated")

   // no request is accepted while a result waits
   `CSC_ASSERT_NOW(a_single, clock, reset, rsp_valid,
      !req_ready, "request taken while a result waits")

endmodule

bind climate_sensor_compensation_unit csc_checker u_csc_checker (.*);
